[rtl/core/sparse_coo_matvec_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the sparse COO matrix-vector block
// Shared property wrappers; define NO_ASSERTIONS to compile them away.
// ---------------------------------------------------------------------------
`ifndef SPARSE_COO_MATVEC_MACROS_SVH
`define SPARSE_COO_MATVEC_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, checked out of reset.
`define SCM_ASSERT_NOW(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("assertion failed");
// Next-cycle implication, checked out of reset.
`define SCM_ASSERT_NEXT(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("assertion failed");
`else
`define SCM_ASSERT_NOW(label, clk, rst_n, a, b)
`define SCM_ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

[rtl/core/scm_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// scm_pkg
// Types and constants of the sparse COO matrix-vector block.
// ---------------------------------------------------------------------------
package scm_pkg;

  // Operation codes carried in the input tuser.
  typedef enum logic [1:0] {
    OP_WRITE_NZ  = 2'd0,
    OP_WRITE_VEC = 2'd1,
    OP_RUN       = 2'd2,
    OP_READ      = 2'd3
  } op_t;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_NNZ  = 2'd0,
    CFG_ROWS = 2'd1,
    CFG_COLS = 2'd2,
    CFG_NONE = 2'd3
  } cfg_idx_t;

  // Result status codes.
  localparam logic [1:0] STATUS_OK  = 2'd0;
  localparam logic [1:0] STATUS_BAD = 2'd1;
  localparam logic [1:0] STATUS_SAT = 2'd2;

  // Controller states.
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FETCH,
    ST_CHECK,
    ST_MUL,
    ST_ACC,
    ST_DONE
  } state_t;

  localparam int unsigned SUM_W = 48;
  localparam int unsigned VAL_W = 32;

endpackage

[rtl/core/sparse_coo_matvec.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sparse_coo_matvec
// Coordinate-form sparse matrix times dense vector, Q16.16 in, Q32.16 out.
// ---------------------------------------------------------------------------
// Usage:
// The input stream carries one command per transfer (tuser: op, transposed).
// Writes of a nonzero or a vector element and result reads answer with one
// result transfer each, passed through the done state into the output register.
// A run first sweeps the result memory to zero, then walks the nonzeros one
// at a time through fetch, range check and reads, multiply, and accumulate
// and write back; a skipped nonzero leaves the walk after the range check.
// All nonzeros go through the one shared multiply-accumulate unit.
// After reset the block sweeps the result memory and holds in_tready low
// meanwhile; configuration writes are always taken.
// A result waits in the output register while the receiver stalls; one more
// command is accepted meanwhile and then holds until the output frees.
// Configuration must be written only while the block is idle.
// ---------------------------------------------------------------------------
module sparse_coo_matvec #(
  parameter int unsigned NONZERO_DEPTH = 1024,
  parameter int unsigned VECTOR_DEPTH  = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input channel.
  input  logic        in_tvalid,
  output logic        in_tready,
  // tdata: entry_index[9:0], row_coord[17:10], col_index[25:18],
  //        element_index[33:26], value[65:34], zero[71:66]
  input  logic [71:0] in_tdata,
  // tuser: op[1:0], transposed[2]
  input  logic [2:0]  in_tuser,
  // Result channel.
  output logic        out_tvalid,
  input  logic        out_tready,
  // tdata: result_value[47:0], skipped_entries[58:48], zero[63:59]
  output logic [63:0] out_tdata,
  // tuser: status[1:0]
  output logic [1:0]  out_tuser,
  // Configuration write channel.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [10:0] cfg_data
);
  import scm_pkg::*;
  `include "sparse_coo_matvec_macros.svh"

  localparam int unsigned NZ_AW = (NONZERO_DEPTH > 1) ? $clog2(NONZERO_DEPTH) : 1;
  localparam int unsigned NZ_CW = $clog2(NONZERO_DEPTH + 1);
  localparam int unsigned VA_AW = (VECTOR_DEPTH > 1) ? $clog2(VECTOR_DEPTH) : 1;
  localparam logic [VA_AW-1:0] VA_LAST = VA_AW'(VECTOR_DEPTH - 1);

  // Input field unpacking.
  logic [9:0]         in_entry;
  logic [7:0]         in_row, in_col, in_elem;
  logic [31:0]        in_value;
  op_t                in_op;
  logic               in_transposed;
  assign in_entry      = in_tdata[9:0];
  assign in_row        = in_tdata[17:10];
  assign in_col        = in_tdata[25:18];
  assign in_elem       = in_tdata[33:26];
  assign in_value      = in_tdata[65:34];
  assign in_op         = op_t'(in_tuser[1:0]);
  assign in_transposed = in_tuser[2];

  // Configuration registers.
  logic [10:0] nnz_r;
  logic [8:0]  rows_r, cols_r;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nnz_r  <= '0;
      rows_r <= 9'd256;
      cols_r <= 9'd256;
    end else if (cfg_valid) begin
      case (cfg_idx_t'(cfg_index))
        CFG_NNZ:  nnz_r  <= cfg_data;
        CFG_ROWS: rows_r <= cfg_data[8:0];
        CFG_COLS: cols_r <= cfg_data[8:0];
        default:  ;
      endcase
    end
  end

  // Control and run state.
  state_t           state_r, state_nxt;
  logic [VA_AW-1:0] clr_idx_r, clr_idx_nxt;
  logic             run_pend_r, run_pend_nxt;
  logic [NZ_CW-1:0] walk_k_r, walk_k_nxt, run_len_r, run_len_nxt;
  logic             trans_r, trans_nxt;
  op_t              op_r, op_nxt;
  logic             bad_r, bad_nxt;
  logic [10:0]      skip_r, skip_nxt;
  logic             sat_r, sat_nxt;
  logic [VA_AW-1:0] dst_r, dst_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [47:0]      out_value_r, out_value_nxt;
  logic [10:0]      out_skip_r, out_skip_nxt;
  logic [1:0]       out_status_r, out_status_nxt;

  // Memory ports.
  logic             nz_we, nz_re;
  logic [NZ_AW-1:0] nz_waddr, nz_raddr;
  logic [47:0]      nz_wdata, nz_rdata_r;
  logic             vec_we, vec_re;
  logic [VA_AW-1:0] vec_waddr, vec_raddr;
  logic [31:0]      vec_rdata_r;
  logic             res_we, res_re;
  logic [VA_AW-1:0] res_waddr, res_raddr;
  logic [47:0]      res_wdata, res_rdata_r;

  logic [47:0] nz_mem  [NONZERO_DEPTH];
  logic [31:0] vec_mem [VECTOR_DEPTH];
  logic [47:0] res_mem [VECTOR_DEPTH];

  // Nonzero memory: {value, column, row} per slot.
  always_ff @(posedge clk) begin
    if (nz_we) begin
      nz_mem[nz_waddr] <= nz_wdata;
    end
    if (nz_re) begin
      nz_rdata_r <= nz_mem[nz_raddr];
    end
  end

  // Dense vector memory.
  always_ff @(posedge clk) begin
    if (vec_we) begin
      vec_mem[vec_waddr] <= in_value;
    end
    if (vec_re) begin
      vec_rdata_r <= vec_mem[vec_raddr];
    end
  end

  // Result memory.
  always_ff @(posedge clk) begin
    if (res_we) begin
      res_mem[res_waddr] <= res_wdata;
    end
    if (res_re) begin
      res_rdata_r <= res_mem[res_raddr];
    end
  end

  // Fields of the fetched nonzero.
  logic [7:0]  nz_row, nz_col;
  logic [31:0] nz_value;
  logic        entry_ok;
  assign nz_row   = nz_rdata_r[7:0];
  assign nz_col   = nz_rdata_r[15:8];
  assign nz_value = nz_rdata_r[47:16];
  assign entry_ok = ({1'b0, nz_row} < rows_r) && ({1'b0, nz_col} < cols_r) &&
                    (32'(nz_row) < VECTOR_DEPTH) && (32'(nz_col) < VECTOR_DEPTH);

  // Multiply-accumulate unit.
  logic signed [47:0] mac_sum;
  logic               mac_sat;
  scm_mac u_mac (
    .clk    (clk),
    .mul_en (state_r == ST_MUL),
    .a      ($signed(nz_value)),
    .b      ($signed(vec_rdata_r)),
    .acc_in ($signed(res_rdata_r)),
    .sum    (mac_sum),
    .sat    (mac_sat)
  );

  logic in_fire, out_free;
  logic [NZ_CW-1:0] walk_k_inc;
  assign in_tready  = state_r == ST_IDLE;
  assign in_fire    = in_tvalid && in_tready;
  assign out_free   = !out_valid_r || out_tready;
  assign walk_k_inc = walk_k_r + NZ_CW'(1);

  // Next state, memory accesses and result formation.
  always_comb begin
    state_nxt      = state_r;
    clr_idx_nxt    = clr_idx_r;
    run_pend_nxt   = run_pend_r;
    walk_k_nxt     = walk_k_r;
    run_len_nxt    = run_len_r;
    trans_nxt      = trans_r;
    op_nxt         = op_r;
    bad_nxt        = bad_r;
    skip_nxt       = skip_r;
    sat_nxt        = sat_r;
    dst_nxt        = dst_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_value_nxt  = out_value_r;
    out_skip_nxt   = out_skip_r;
    out_status_nxt = out_status_r;
    nz_we     = 1'b0;
    nz_re     = 1'b0;
    nz_waddr  = NZ_AW'(in_entry);
    nz_raddr  = NZ_AW'(walk_k_r);
    nz_wdata  = {in_value, in_col, in_row};
    vec_we    = 1'b0;
    vec_re    = 1'b0;
    vec_waddr = VA_AW'(in_elem);
    vec_raddr = trans_r ? VA_AW'(nz_row) : VA_AW'(nz_col);
    res_we    = 1'b0;
    res_re    = 1'b0;
    res_waddr = clr_idx_r;
    res_wdata = '0;
    res_raddr = VA_AW'(in_elem);
    case (state_r)
      ST_CLEAR: begin
        res_we = 1'b1;
        clr_idx_nxt = clr_idx_r + VA_AW'(1);
        if (clr_idx_r == VA_LAST) begin
          clr_idx_nxt = '0;
          if (!run_pend_r) begin
            state_nxt = ST_IDLE;
          end else if (run_len_r == '0) begin
            state_nxt = ST_DONE;
          end else begin
            state_nxt = ST_FETCH;
          end
        end
      end
      ST_IDLE: begin
        if (in_fire) begin
          op_nxt  = in_op;
          bad_nxt = 1'b0;
          state_nxt = ST_DONE;
          case (in_op)
            OP_WRITE_NZ: begin
              if (32'(in_entry) < NONZERO_DEPTH) begin
                nz_we = 1'b1;
              end else begin
                bad_nxt = 1'b1;
              end
            end
            OP_WRITE_VEC: begin
              if (32'(in_elem) < VECTOR_DEPTH) begin
                vec_we = 1'b1;
              end else begin
                bad_nxt = 1'b1;
              end
            end
            OP_RUN: begin
              trans_nxt    = in_transposed;
              skip_nxt     = '0;
              sat_nxt      = 1'b0;
              walk_k_nxt   = '0;
              run_pend_nxt = 1'b1;
              run_len_nxt  = (32'(nnz_r) > NONZERO_DEPTH) ? NZ_CW'(NONZERO_DEPTH)
                                                          : NZ_CW'(nnz_r);
              state_nxt    = ST_CLEAR;
            end
            OP_READ: begin
              if (32'(in_elem) < VECTOR_DEPTH) begin
                res_re = 1'b1;
              end else begin
                bad_nxt = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      ST_FETCH: begin
        nz_re = 1'b1;
        state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        if (entry_ok) begin
          vec_re    = 1'b1;
          res_re    = 1'b1;
          res_raddr = trans_r ? VA_AW'(nz_col) : VA_AW'(nz_row);
          dst_nxt   = res_raddr;
          state_nxt = ST_MUL;
        end else begin
          if (skip_r != '1) begin
            skip_nxt = skip_r + 11'd1;
          end
          walk_k_nxt = walk_k_inc;
          state_nxt  = (walk_k_inc == run_len_r) ? ST_DONE : ST_FETCH;
        end
      end
      ST_MUL: begin
        state_nxt = ST_ACC;
      end
      ST_ACC: begin
        res_we    = 1'b1;
        res_waddr = dst_r;
        res_wdata = mac_sum;
        if (mac_sat) begin
          sat_nxt = 1'b1;
        end
        walk_k_nxt = walk_k_inc;
        state_nxt  = (walk_k_inc == run_len_r) ? ST_DONE : ST_FETCH;
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_value_nxt  = (op_r == OP_READ && !bad_r) ? res_rdata_r : '0;
          out_skip_nxt   = skip_r;
          out_status_nxt = bad_r ? STATUS_BAD : (sat_r ? STATUS_SAT : STATUS_OK);
          run_pend_nxt   = 1'b0;
          state_nxt      = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_idx_r   <= '0;
      run_pend_r  <= 1'b0;
      walk_k_r    <= '0;
      run_len_r   <= '0;
      skip_r      <= '0;
      sat_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_idx_r   <= clr_idx_nxt;
      run_pend_r  <= run_pend_nxt;
      walk_k_r    <= walk_k_nxt;
      run_len_r   <= run_len_nxt;
      skip_r      <= skip_nxt;
      sat_r       <= sat_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    trans_r      <= trans_nxt;
    op_r         <= op_nxt;
    bad_r        <= bad_nxt;
    dst_r        <= dst_nxt;
    out_value_r  <= out_value_nxt;
    out_skip_r   <= out_skip_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, out_skip_r, out_value_r};
  assign out_tuser  = out_status_r;

  // A multiply is always followed by its write back.
  `SCM_ASSERT_NEXT(a_mul_then_acc, clk, rst_n, state_r == ST_MUL, state_r == ST_ACC)
  // A skipped nonzero never reaches the multiplier.
  `SCM_ASSERT_NEXT(a_skip_no_mul, clk, rst_n, state_r == ST_CHECK && !entry_ok,
                   state_r != ST_MUL)
  // The walk never goes past the run length.
  `SCM_ASSERT_NOW(a_walk_range, clk, rst_n, state_r == ST_FETCH, walk_k_r < run_len_r)
  // Starting a run clears the skip count and the saturation flag.
  `SCM_ASSERT_NEXT(a_run_clears, clk, rst_n, in_fire && in_op == OP_RUN,
                   skip_r == '0 && !sat_r && state_r == ST_CLEAR)

endmodule

[rtl/core/scm_mac.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// scm_mac
// Q16.16 multiply, floor to Q32.16, saturating 48-bit accumulate.
// ---------------------------------------------------------------------------
module scm_mac (
  input  logic                              clk,
  input  logic                              mul_en,
  input  logic signed [scm_pkg::VAL_W-1:0]  a,
  input  logic signed [scm_pkg::VAL_W-1:0]  b,
  input  logic signed [scm_pkg::SUM_W-1:0]  acc_in,
  output logic signed [scm_pkg::SUM_W-1:0]  sum,
  output logic                              sat
);
  import scm_pkg::*;

  logic signed [2*VAL_W-1:0] prod_r;
  logic signed [SUM_W-1:0]   term;
  logic signed [SUM_W:0]     wide;

  // Product register; the multiplier stands alone in its cycle.
  always_ff @(posedge clk) begin
    if (mul_en) begin
      prod_r <= a * b;
    end
  end

  // Dropping the low 16 bits of a two's complement product is a floor.
  // The magnitude is at most 2^62, so bits 63:16 hold the whole term.
  always_comb begin
    term = prod_r[2*VAL_W-1:16];
    wide = {acc_in[SUM_W-1], acc_in} + {term[SUM_W-1], term};
    sat  = wide[SUM_W] != wide[SUM_W-1];
    if (!sat) begin
      sum = wide[SUM_W-1:0];
    end else if (wide[SUM_W]) begin
      sum = {1'b1, {(SUM_W-1){1'b0}}};
    end else begin
      sum = {1'b0, {(SUM_W-1){1'b1}}};
    end
  end

endmodule
